// ===== sv/lcv_pkg.sv =====
// Package: sizes, cell control struct and length helper for the convolution core.
`default_nettype none
package lcv_pkg;

    localparam int MAX_FIRST_LEN  = 32;
    localparam int MAX_SECOND_LEN = 32;
    localparam int SAMPLE_WIDTH   = 16;

    localparam int CFG_W   = 6;
    localparam int VALUE_W = 38;
    localparam int PROD_W  = 2 * SAMPLE_WIDTH;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam int MAX_LEN = (MAX_FIRST_LEN > MAX_SECOND_LEN) ? MAX_FIRST_LEN : MAX_SECOND_LEN;
    localparam int NCELL   = MAX_LEN;
    localparam int LEN_W   = ($clog2(MAX_LEN + 1) > CFG_W) ? $clog2(MAX_LEN + 1) : CFG_W;
    localparam int RUN_W   = LEN_W + 1;

    localparam logic REG_X_LENGTH = 1'b0;
    localparam logic REG_Y_LENGTH = 1'b1;

    localparam logic OP_LOAD_FIRST  = 1'b0;
    localparam logic OP_LOAD_SECOND = 1'b1;

    localparam logic [CFG_W-1:0] X_LENGTH_RESET = CFG_W'(8);
    localparam logic [CFG_W-1:0] Y_LENGTH_RESET = CFG_W'(2);

    typedef struct packed {
        logic                           en;
        logic                           shift;
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic signed [SAMPLE_WIDTH-1:0] u;
    } t_cell_ctl;

    function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] r,
                                                 input logic [LEN_W-1:0] maxlen);
        logic [LEN_W-1:0] rv;
        rv = LEN_W'(r);
        if (rv == '0) begin
            return LEN_W'(1);
        end
        if (rv > maxlen) begin
            return maxlen;
        end
        return rv;
    endfunction

endpackage
`default_nettype wire

// ===== sv/lcv_cell.sv =====
// One convolution cell: first and second sample, product and partial sum.
`default_nettype none
module lcv_cell
    import lcv_pkg::*;
(
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire t_cell_ctl                      i_ctl,
    input  wire logic                           i_wr_x,
    input  wire logic                           i_wr_y,
    input  wire logic                           i_active,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_y_next,
    output      logic signed [SAMPLE_WIDTH-1:0] o_y,
    input  wire logic signed [VALUE_W-1:0]      i_sum_next,
    output      logic signed [VALUE_W-1:0]      o_sum
);

    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic signed [SAMPLE_WIDTH-1:0] r_y;
    logic signed [PROD_W-1:0]       r_prod;
    logic signed [VALUE_W-1:0]      r_sum;
    logic signed [PROD_W-1:0]       w_prod;

    assign w_prod = r_x * i_ctl.u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
        end else if (i_wr_x) begin
            r_x <= i_ctl.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_y) begin
            r_y <= i_ctl.sample;
        end else if (i_ctl.shift) begin
            r_y <= i_y_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod <= '0;
            r_sum  <= '0;
        end else if (i_ctl.en) begin
            r_prod <= i_active ? w_prod : '0;
            r_sum  <= VALUE_W'(r_prod) + i_sum_next;
        end
    end

    assign o_y   = r_y;
    assign o_sum = r_sum;

endmodule
`default_nettype wire

// ===== sv/linear_convolution_core.sv =====
// Top level: full linear convolution over a chain of multiply-accumulate cells.
//
// Input channel (i_in_valid / o_in_ready): each transfer loads one signed sample,
// into the first sequence when i_operation is 0, else into the second. Loads into
// a sequence already holding its length are dropped. o_in_ready is high only while
// no run is in progress.
// When both sequences are full, the run starts: x_length + y_length - 1 results
// (each length clamped to 1..32) leave on the output channel (o_out_valid /
// i_out_ready), the final one with o_last set. The second sequence shifts out of
// the cell chain one sample per cycle while the receiver is ready, then zeros, and
// each sample is broadcast to every cell; each cell multiplies it by its sample
// of the first sequence and adds its neighbor's partial sum, so one result leaves
// per cycle while the receiver is ready. The broadcast sample is registered in
// r_u, products in r_prod and sums in r_sum; loads are taken back to back while idle.
// A stalled receiver freezes the whole chain; nothing is lost or repeated.
// Reset (synchronous, active low) clears both load counters, the chain sums and
// sets x_length to 8, y_length to 2. The user writes lengths over the APB port
// (x_length 0x0, y_length 0x4) only while no run is in progress; not enforced.
`default_nettype none
module linear_convolution_core
    import lcv_pkg::*;
(
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ADDR_W-1:0]              paddr,
    input  wire logic [DATA_W-1:0]              pwdata,
    output      logic [DATA_W-1:0]              prdata,
    output      logic                           pready,
    input  wire logic                           i_in_valid,
    output      logic                           o_in_ready,
    input  wire logic                           i_operation,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output      logic                           o_out_valid,
    input  wire logic                           i_out_ready,
    output      logic signed [VALUE_W-1:0]      o_value,
    output      logic                           o_last
);

    typedef enum logic [1:0] {S_IDLE, S_FEED, S_DRAIN} t_state;

    t_state r_state;
    logic [CFG_W-1:0] r_x_length;
    logic [CFG_W-1:0] r_y_length;
    logic [LEN_W-1:0] r_cx;
    logic [LEN_W-1:0] r_cy;
    logic [RUN_W-1:0] r_feed;
    logic [RUN_W-1:0] r_lz;
    logic signed [SAMPLE_WIDTH-1:0] r_u;
    logic r_uv, r_ul, r_pv, r_pl, r_sv, r_sl;

    logic [LEN_W-1:0] w_lx, w_ly;
    logic [LEN_W-1:0] n_cx, n_cy;
    logic w_in_xfer, w_load_x, w_load_y, w_full, w_en, w_feed_last, w_cfg_wr;
    t_cell_ctl w_ctl;
    logic [NCELL-1:0] w_wr_x, w_wr_y, w_active;
    logic signed [SAMPLE_WIDTH-1:0] w_y [NCELL+1];
    logic signed [VALUE_W-1:0]      w_sum [NCELL+1];

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_Y_LENGTH) ? DATA_W'(r_y_length) : DATA_W'(r_x_length);

    assign w_lx = eff_len(r_x_length, LEN_W'(MAX_FIRST_LEN));
    assign w_ly = eff_len(r_y_length, LEN_W'(MAX_SECOND_LEN));

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_load_x    = w_in_xfer && (i_operation == OP_LOAD_FIRST) && (r_cx < w_lx);
    assign w_load_y    = w_in_xfer && (i_operation == OP_LOAD_SECOND) && (r_cy < w_ly);
    assign n_cx        = w_load_x ? r_cx + LEN_W'(1) : r_cx;
    assign n_cy        = w_load_y ? r_cy + LEN_W'(1) : r_cy;
    assign w_full      = w_in_xfer && (n_cx >= w_lx) && (n_cy >= w_ly);
    assign w_en        = !r_sv || i_out_ready;
    assign w_feed_last = (r_feed == r_lz - RUN_W'(1));

    assign w_ctl.en     = w_en;
    assign w_ctl.shift  = (r_state == S_FEED) && w_en;
    assign w_ctl.sample = i_sample;
    assign w_ctl.u      = r_u;

    assign w_y[NCELL]   = '0;
    assign w_sum[NCELL] = '0;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        assign w_wr_x[k]   = w_load_x && (r_cx == LEN_W'(k));
        assign w_wr_y[k]   = w_load_y && (r_cy == LEN_W'(k));
        assign w_active[k] = (LEN_W'(k) < w_lx);

        lcv_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_wr_x     (w_wr_x[k]),
            .i_wr_y     (w_wr_y[k]),
            .i_active   (w_active[k]),
            .i_y_next   (w_y[k+1]),
            .o_y        (w_y[k]),
            .i_sum_next (w_sum[k+1]),
            .o_sum      (w_sum[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_length <= X_LENGTH_RESET;
            r_y_length <= Y_LENGTH_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_Y_LENGTH) begin
                r_y_length <= pwdata[CFG_W-1:0];
            end else begin
                r_x_length <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cx    <= '0;
            r_cy    <= '0;
            r_feed  <= '0;
            r_lz    <= '0;
            r_u     <= '0;
            r_uv    <= 1'b0;
            r_ul    <= 1'b0;
            r_pv    <= 1'b0;
            r_pl    <= 1'b0;
            r_sv    <= 1'b0;
            r_sl    <= 1'b0;
        end else begin
            if (w_en) begin
                r_pv <= r_uv;
                r_pl <= r_ul;
                r_sv <= r_pv;
                r_sl <= r_pl;
                r_u  <= '0;
                r_uv <= 1'b0;
                r_ul <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_full) begin
                        r_cx    <= '0;
                        r_cy    <= '0;
                        r_feed  <= '0;
                        r_lz    <= RUN_W'(w_lx) + RUN_W'(w_ly) - RUN_W'(1);
                        r_state <= S_FEED;
                    end else begin
                        r_cx <= n_cx;
                        r_cy <= n_cy;
                    end
                end
                S_FEED: begin
                    if (w_en) begin
                        r_u  <= (r_feed < RUN_W'(w_ly)) ? w_y[0] : '0;
                        r_uv <= 1'b1;
                        r_ul <= w_feed_last;
                        if (w_feed_last) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_feed <= r_feed + RUN_W'(1);
                        end
                    end
                end
                S_DRAIN: begin
                    if (r_sv && r_sl && i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_sv;
    assign o_last      = r_sl;
    assign o_value     = w_sum[0];

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("result pending while loads are open");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last && i_out_ready) |=> o_in_ready)
        else $error("input not reopened after final transfer");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !(r_uv || r_pv))
        else $error("valid tag in chain while idle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |=> (!o_in_ready && r_cx == '0 && r_cy == '0))
        else $error("run start did not close input and clear counters");

endmodule
`default_nettype wire
